>>> design/brb_pkg.sv
// Shared types and codes for the circular byte buffer.
package brb_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_MOVE = 2'd2
  } state_t;

  typedef logic [8:0] fill_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic [7:0] position;
    logic [8:0] span;
  } in_word_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] read_byte;
    fill_t      fill_level;
  } out_word_t;

endpackage

>>> design/byte_ring_buffer_with_range_remove.sv
// Top level of the circular byte buffer with push, indexed read and range remove.
//
// The buffer holds up to CAPACITY bytes in logical order, counted from a head
// pointer, in one simple dual-port memory with a registered read. Each input
// word (push, read or remove) yields exactly one result word carrying ok, the
// byte read and the fill level after the operation. A push, a failed
// operation, a zero-span remove, a remove from the head and a remove that
// reaches the end each load their result in the cycle that accepts them, so
// with the result side always ready these run at one word per cycle. A
// successful read loads its result from the read state because of the
// registered memory read. A remove in the middle walks the tail through the
// memory in the move state, one byte per cycle with read and write overlapped.
// A new word is taken only when the block is idle and its result register is
// empty or being drained. The memory needs no clearing after reset; only
// pushed bytes are ever in range.
// fill_level reports the byte count modulo 512.
module byte_ring_buffer_with_range_remove #(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brb_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output brb_pkg::out_word_t  out_data
);

  // address, count and logical-index widths
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > 9) ? CW : 9;
  localparam logic [LW:0] CAP_L = (LW + 1)'(CAPACITY);

  typedef logic [LW-1:0] lidx_t;
  typedef logic [CW-1:0] cnt_t;

  // map a logical index to a physical address (index below CAPACITY)
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input lidx_t idx);
    logic [LW:0] sum;
    sum = {{(LW + 1 - AW){1'b0}}, head} + {1'b0, idx};
    if (sum >= CAP_L) begin
      sum = sum - CAP_L;
    end
    return sum[AW-1:0];
  endfunction

  brb_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  cnt_t               count_r, count_nxt;
  lidx_t              src_r, src_nxt;
  lidx_t              dst_r, dst_nxt;
  lidx_t              span_r, span_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  brb_pkg::out_word_t out_data_r, out_data_nxt;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [7:0]         mem_wdata, mem_rdata;

  logic               in_fire;
  lidx_t              pos_l, span_l, count_l;
  logic               rd_hit, rm_bad, rm_zero, rm_tail, rm_middle;
  logic               move_issue, move_done;

  brb_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // take a word only when idle and the result slot is free or draining
  assign in_ready  = (state_r == brb_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_l   = lidx_t'(in_data.position);
  assign span_l  = lidx_t'(in_data.span);
  assign count_l = lidx_t'(count_r);

  // classify the incoming word
  assign rd_hit    = (pos_l < count_l);
  assign rm_bad    = (pos_l >= count_l);
  assign rm_zero   = (span_l == '0);
  assign rm_tail   = (span_l >= (count_l - pos_l));
  assign rm_middle = !rm_bad && !rm_zero && (pos_l != '0) && !rm_tail;

  // tail walk: read the source byte ahead, write it back in the next cycle
  assign move_issue = (src_r < count_l);
  assign move_done  = !move_issue && !pend_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((in_data.operation == brb_pkg::OP_READ) && rd_hit) begin
            state_nxt = brb_pkg::ST_READ;
          end else if ((in_data.operation == brb_pkg::OP_REMOVE) && rm_middle) begin
            state_nxt = brb_pkg::ST_MOVE;
          end
        end
      end
      brb_pkg::ST_READ: begin
        state_nxt = brb_pkg::ST_IDLE;
      end
      brb_pkg::ST_MOVE: begin
        if (move_done) begin
          state_nxt = brb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = brb_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath, memory control and result
  always_comb begin
    logic               load;
    brb_pkg::out_word_t res;

    load          = 1'b0;
    res           = '0;
    head_nxt      = head_r;
    count_nxt     = count_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    span_nxt      = span_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.operation)
            brb_pkg::OP_PUSH: begin
              if ({1'b0, count_l} < CAP_L) begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_r, count_l);
                mem_wdata = in_data.byte_value;
                count_nxt = count_r + cnt_t'(1);
                res.ok    = 1'b1;
              end
              load = 1'b1;
            end
            brb_pkg::OP_READ: begin
              // a hit returns its result from the read state
              if (rd_hit) begin
                mem_re    = 1'b1;
                mem_raddr = phys(head_r, pos_l);
              end else begin
                load = 1'b1;
              end
            end
            brb_pkg::OP_REMOVE: begin
              if (rm_bad) begin
                load = 1'b1;
              end else if (rm_zero) begin
                res.ok = 1'b1;
                load   = 1'b1;
              end else if (pos_l == '0) begin
                if (span_l >= count_l) begin
                  head_nxt  = '0;
                  count_nxt = '0;
                end else begin
                  head_nxt  = phys(head_r, span_l);
                  count_nxt = cnt_t'(count_l - span_l);
                end
                res.ok = 1'b1;
                load   = 1'b1;
              end else if (rm_tail) begin
                count_nxt = cnt_t'(pos_l);
                res.ok    = 1'b1;
                load      = 1'b1;
              end else begin
                src_nxt  = pos_l + span_l;
                dst_nxt  = pos_l;
                span_nxt = span_l;
                pend_nxt = 1'b0;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
          res.fill_level = brb_pkg::fill_t'(count_nxt);
        end
      end
      brb_pkg::ST_READ: begin
        res.ok         = 1'b1;
        res.read_byte  = mem_rdata;
        res.fill_level = brb_pkg::fill_t'(count_r);
        load           = 1'b1;
      end
      brb_pkg::ST_MOVE: begin
        if (move_issue) begin
          mem_re    = 1'b1;
          mem_raddr = phys(head_r, src_r);
          src_nxt   = src_r + lidx_t'(1);
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_r, dst_r);
          mem_wdata = mem_rdata;
          dst_nxt   = dst_r + lidx_t'(1);
        end
        pend_nxt = move_issue;
        if (move_done) begin
          count_nxt      = cnt_t'(count_l - span_r);
          res.ok         = 1'b1;
          res.fill_level = brb_pkg::fill_t'(count_nxt);
          load           = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brb_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk indexes
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    span_r     <= span_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // the fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, lidx_t'(count_r)} <= CAP_L)
    else $error("byte count above capacity");

  // the head stays a valid physical address
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {{(LW + 1 - AW){1'b0}}, head_r} < CAP_L)
    else $error("head pointer out of range");

  // while a word is in flight the result slot is empty
  a_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != brb_pkg::ST_IDLE) |-> !out_valid_r)
    else $error("result slot busy while a word is in flight");

  // the tail walk never reads the entry it is writing
  a_move_no_alias: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brb_pkg::ST_MOVE && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("tail walk read and write collide");
`endif

endmodule

>>> design/brb_ram.sv
// Simple dual-port byte memory with one write port and a registered read port.
module brb_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the last word read until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
